[hdl/lprf_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, field types and inter-module structs of the record FIFO.
package lprf_pkg;

   // Byte store size and the widths that follow from it.
   localparam int CAPACITY  = 1024;
   localparam int POS_W     = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int HDR_BYTES = 4;

   // Fixed widths of the beat fields.
   localparam int ACTION_W       = 3;
   localparam int BYTE_COUNT_W   = 11;
   localparam int DATA_W         = 8;
   localparam int STATUS_W       = 2;
   localparam int STORED_LEN_W   = 10;
   localparam int FREE_SPACE_W   = 11;
   localparam int HDR_W          = 8 * HDR_BYTES;

   // Width that holds free space plus a record length plus the header.
   localparam int SUM_W = ((CNT_W > BYTE_COUNT_W) ? CNT_W : BYTE_COUNT_W) + 2;
   localparam int END_W = CNT_W + 1;

   typedef logic [POS_W-1:0]        pos_type;
   typedef logic [CNT_W-1:0]        cnt_type;
   typedef logic [SUM_W-1:0]        sum_type;
   typedef logic [END_W-1:0]        end_type;
   typedef logic [DATA_W-1:0]       byte_type;
   typedef logic [HDR_W-1:0]        hdr_type;
   typedef logic [BYTE_COUNT_W-1:0] byte_count_type;
   typedef logic [STORED_LEN_W-1:0] stored_len_type;
   typedef logic [FREE_SPACE_W-1:0] free_space_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH_START = 3'd0,
      ACT_PUSH_BYTE  = 3'd1,
      ACT_POP_START  = 3'd2,
      ACT_POP_BYTE   = 3'd3,
      ACT_CLEAR      = 3'd4
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK      = 2'd0,
      STS_NO_ROOM = 2'd1,
      STS_EMPTY   = 2'd2,
      STS_SEQ     = 2'd3
   } status_type;

   typedef struct packed {
      status_type     status;
      byte_type       read_byte;
      stored_len_type stored_length;
      logic           last_byte;
      logic           queue_empty;
      free_space_type free_space;
   } result_type;

   typedef struct packed {
      logic     wr_en;
      pos_type  wr_addr;
      byte_type wr_data;
      logic     rd_en;
      pos_type  rd_addr;
   } ram_req_type;

endpackage

[hdl/lprf_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response beats.
interface lprf_req_if;
   logic                                valid;
   logic                                ready;
   logic [lprf_pkg::ACTION_W-1:0]       action;
   logic [lprf_pkg::BYTE_COUNT_W-1:0]   byte_count;
   logic [lprf_pkg::DATA_W-1:0]         data_byte;

   modport source (output valid, action, byte_count, data_byte, input ready);
   modport sink   (input valid, action, byte_count, data_byte, output ready);
endinterface

interface lprf_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [lprf_pkg::STATUS_W-1:0]       status;
   logic [lprf_pkg::DATA_W-1:0]         read_byte;
   logic [lprf_pkg::STORED_LEN_W-1:0]   stored_length;
   logic                                last_byte;
   logic                                queue_empty;
   logic [lprf_pkg::FREE_SPACE_W-1:0]   free_space;

   modport source (output valid, status, read_byte, stored_length, last_byte,
                   queue_empty, free_space, input ready);
   modport sink   (input valid, status, read_byte, stored_length, last_byte,
                   queue_empty, free_space, output ready);
endinterface

[hdl/lprf_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
module lprf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/lprf_seq.sv]
`timescale 1ns / 1ps
// Sequencer: queue pointers, header transfer and per-item decisions.
module lprf_seq (
   input  logic                   clock,
   input  logic                   reset,
   lprf_req_if.sink               req_ch,
   input  logic                   slot_free,
   input  lprf_pkg::byte_type     ram_rd_data,
   output lprf_pkg::ram_req_type  ram_req,
   output logic                   res_valid,
   output lprf_pkg::result_type   res
);

   typedef enum logic [6:0] {
      S_IDLE      = 7'b0000001,
      S_HDR_WRITE = 7'b0000010,
      S_HDR_READ  = 7'b0000100,
      S_POP_CALC  = 7'b0001000,
      S_POP_SETUP = 7'b0010000,
      S_POP_DATA  = 7'b0100000,
      S_RESULT    = 7'b1000000
   } state_type;

   state_type                state_ff, state_in;
   lprf_pkg::pos_type        wr_pos_ff, wr_pos_in;
   lprf_pkg::pos_type        rd_pos_ff, rd_pos_in;
   lprf_pkg::cnt_type        free_ff, free_in;
   lprf_pkg::cnt_type        push_pend_ff, push_pend_in;
   lprf_pkg::cnt_type        pop_pend_ff, pop_pend_in;
   lprf_pkg::pos_type        rec_end_ff, rec_end_in;
   lprf_pkg::cnt_type        rec_size_ff, rec_size_in;
   lprf_pkg::byte_count_type count_ff, count_in;
   logic [1:0]               hdr_idx_ff, hdr_idx_in;
   lprf_pkg::hdr_type        hdr_raw_ff, hdr_raw_in;
   lprf_pkg::status_type     status_ff, status_in;
   lprf_pkg::byte_type       read_byte_ff, read_byte_in;
   lprf_pkg::stored_len_type stored_len_ff, stored_len_in;
   logic                     last_ff, last_in;

   logic                     accept;
   logic                     busy;
   lprf_pkg::sum_type        need;
   logic                     no_room;
   lprf_pkg::cnt_type        free_after_push;
   lprf_pkg::sum_type        free_pop_sum;
   lprf_pkg::cnt_type        free_after_pop;
   lprf_pkg::end_type        end_sum;
   lprf_pkg::pos_type        end_calc;
   lprf_pkg::cnt_type        copy_limit;
   lprf_pkg::hdr_type        hdr_word;
   logic                     queue_empty;

   function automatic lprf_pkg::pos_type next_pos(input lprf_pkg::pos_type p);
      return (p == lprf_pkg::pos_type'(lprf_pkg::CAPACITY - 1)) ?
             '0 : p + lprf_pkg::pos_type'(1);
   endfunction

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign busy         = (push_pend_ff != '0) || (pop_pend_ff != '0);
   assign queue_empty  = (free_ff == lprf_pkg::cnt_type'(lprf_pkg::CAPACITY));

   // Room check and reservation for a new record.
   assign need = lprf_pkg::sum_type'(req_ch.byte_count) +
                 lprf_pkg::sum_type'(lprf_pkg::HDR_BYTES);
   assign no_room = lprf_pkg::sum_type'(free_ff) < need;
   assign free_after_push = lprf_pkg::cnt_type'(lprf_pkg::sum_type'(free_ff) - need);

   // Space released when a record is retired, saturated at the capacity.
   assign free_pop_sum = lprf_pkg::sum_type'(free_ff) + lprf_pkg::sum_type'(rec_size_ff) +
                         lprf_pkg::sum_type'(lprf_pkg::HDR_BYTES);
   assign free_after_pop = (free_pop_sum > lprf_pkg::sum_type'(lprf_pkg::CAPACITY)) ?
                           lprf_pkg::cnt_type'(lprf_pkg::CAPACITY) :
                           lprf_pkg::cnt_type'(free_pop_sum);

   // End of the record: the sum stays below twice the capacity.
   assign end_sum  = lprf_pkg::end_type'(rd_pos_ff) + lprf_pkg::end_type'(rec_size_ff);
   assign end_calc = (end_sum >= lprf_pkg::end_type'(lprf_pkg::CAPACITY)) ?
                     lprf_pkg::pos_type'(end_sum - lprf_pkg::end_type'(lprf_pkg::CAPACITY)) :
                     lprf_pkg::pos_type'(end_sum);

   assign copy_limit = (lprf_pkg::sum_type'(rec_size_ff) < lprf_pkg::sum_type'(count_ff)) ?
                       rec_size_ff : lprf_pkg::cnt_type'(count_ff);

   assign hdr_word = lprf_pkg::hdr_type'(count_ff);

   always_comb begin
      state_in      = state_ff;
      wr_pos_in     = wr_pos_ff;
      rd_pos_in     = rd_pos_ff;
      free_in       = free_ff;
      push_pend_in  = push_pend_ff;
      pop_pend_in   = pop_pend_ff;
      rec_end_in    = rec_end_ff;
      rec_size_in   = rec_size_ff;
      count_in      = count_ff;
      hdr_idx_in    = hdr_idx_ff;
      hdr_raw_in    = hdr_raw_ff;
      status_in     = status_ff;
      read_byte_in  = read_byte_ff;
      stored_len_in = stored_len_ff;
      last_in       = last_ff;
      res_valid     = 1'b0;

      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = wr_pos_ff;
      ram_req.wr_data = hdr_word[{hdr_idx_ff, 3'b000} +: lprf_pkg::DATA_W];
      ram_req.rd_en   = 1'b0;
      ram_req.rd_addr = rd_pos_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               status_in     = lprf_pkg::STS_OK;
               read_byte_in  = '0;
               stored_len_in = '0;
               last_in       = 1'b0;
               count_in      = req_ch.byte_count;
               state_in      = S_RESULT;
               unique case (lprf_pkg::action_type'(req_ch.action))
                  lprf_pkg::ACT_PUSH_START: begin
                     if (busy) begin
                        status_in = lprf_pkg::STS_SEQ;
                     end else if (no_room) begin
                        status_in = lprf_pkg::STS_NO_ROOM;
                     end else begin
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_data = req_ch.byte_count[lprf_pkg::DATA_W-1:0];
                        wr_pos_in       = next_pos(wr_pos_ff);
                        free_in         = free_after_push;
                        push_pend_in    = lprf_pkg::cnt_type'(req_ch.byte_count);
                        hdr_idx_in      = 2'd1;
                        state_in        = S_HDR_WRITE;
                     end
                  end
                  lprf_pkg::ACT_PUSH_BYTE: begin
                     if (push_pend_ff == '0) begin
                        status_in = lprf_pkg::STS_SEQ;
                     end else begin
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_data = req_ch.data_byte;
                        wr_pos_in       = next_pos(wr_pos_ff);
                        push_pend_in    = push_pend_ff - lprf_pkg::cnt_type'(1);
                     end
                  end
                  lprf_pkg::ACT_POP_START: begin
                     if (busy) begin
                        status_in = lprf_pkg::STS_SEQ;
                     end else if (queue_empty) begin
                        status_in = lprf_pkg::STS_EMPTY;
                     end else begin
                        ram_req.rd_en = 1'b1;
                        rd_pos_in     = next_pos(rd_pos_ff);
                        hdr_idx_in    = 2'd0;
                        state_in      = S_HDR_READ;
                     end
                  end
                  lprf_pkg::ACT_POP_BYTE: begin
                     if (pop_pend_ff == '0) begin
                        status_in = lprf_pkg::STS_SEQ;
                     end else begin
                        ram_req.rd_en = 1'b1;
                        rd_pos_in     = next_pos(rd_pos_ff);
                        pop_pend_in   = pop_pend_ff - lprf_pkg::cnt_type'(1);
                        state_in      = S_POP_DATA;
                        if (pop_pend_ff == lprf_pkg::cnt_type'(1)) begin
                           // Last copied byte: skip the rest and release the record.
                           last_in   = 1'b1;
                           rd_pos_in = rec_end_ff;
                           free_in   = free_after_pop;
                        end
                     end
                  end
                  lprf_pkg::ACT_CLEAR: begin
                     free_in      = lprf_pkg::cnt_type'(lprf_pkg::CAPACITY);
                     rd_pos_in    = wr_pos_ff;
                     push_pend_in = '0;
                     pop_pend_in  = '0;
                  end
                  default: begin
                     status_in = lprf_pkg::STS_SEQ;
                  end
               endcase
            end
         end
         S_HDR_WRITE: begin
            ram_req.wr_en = 1'b1;
            wr_pos_in     = next_pos(wr_pos_ff);
            if (hdr_idx_ff == 2'd3) begin
               state_in = S_RESULT;
            end else begin
               hdr_idx_in = hdr_idx_ff + 2'd1;
            end
         end
         S_HDR_READ: begin
            // Header bytes arrive least significant first.
            hdr_raw_in = {ram_rd_data, hdr_raw_ff[lprf_pkg::HDR_W-1:lprf_pkg::DATA_W]};
            if (hdr_idx_ff == 2'd3) begin
               state_in = S_POP_CALC;
            end else begin
               ram_req.rd_en = 1'b1;
               rd_pos_in     = next_pos(rd_pos_ff);
               hdr_idx_in    = hdr_idx_ff + 2'd1;
            end
         end
         S_POP_CALC: begin
            rec_size_in = (hdr_raw_ff > lprf_pkg::hdr_type'(lprf_pkg::CAPACITY)) ?
                          lprf_pkg::cnt_type'(lprf_pkg::CAPACITY) :
                          lprf_pkg::cnt_type'(hdr_raw_ff);
            state_in    = S_POP_SETUP;
         end
         S_POP_SETUP: begin
            rec_end_in    = end_calc;
            stored_len_in = lprf_pkg::stored_len_type'(rec_size_ff);
            pop_pend_in   = copy_limit;
            if (copy_limit == '0) begin
               rd_pos_in = end_calc;
               free_in   = free_after_pop;
            end
            state_in = S_RESULT;
         end
         S_POP_DATA: begin
            read_byte_in = ram_rd_data;
            state_in     = S_RESULT;
         end
         S_RESULT: begin
            res_valid = 1'b1;
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wr_pos_ff    <= '0;
         rd_pos_ff    <= '0;
         free_ff      <= lprf_pkg::cnt_type'(lprf_pkg::CAPACITY);
         push_pend_ff <= '0;
         pop_pend_ff  <= '0;
         rec_end_ff   <= '0;
         rec_size_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         wr_pos_ff    <= wr_pos_in;
         rd_pos_ff    <= rd_pos_in;
         free_ff      <= free_in;
         push_pend_ff <= push_pend_in;
         pop_pend_ff  <= pop_pend_in;
         rec_end_ff   <= rec_end_in;
         rec_size_ff  <= rec_size_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff      <= count_in;
      hdr_idx_ff    <= hdr_idx_in;
      hdr_raw_ff    <= hdr_raw_in;
      status_ff     <= status_in;
      read_byte_ff  <= read_byte_in;
      stored_len_ff <= stored_len_in;
      last_ff       <= last_in;
   end

   assign res.status        = status_ff;
   assign res.read_byte     = read_byte_ff;
   assign res.stored_length = stored_len_ff;
   assign res.last_byte     = last_ff;
   assign res.queue_empty   = queue_empty;
   assign res.free_space    = lprf_pkg::free_space_type'(free_ff);

endmodule

[hdl/length_prefixed_record_fifo_core.sv]
`timescale 1ns / 1ps
// Top level of the length-prefixed record FIFO: sequencer, byte store, response slot.
//
//   Channel   Direction  Beat contents
//   req_ch    in         action, byte_count, data_byte
//   rsp_ch    out        status, read_byte, stored_length, last_byte, queue_empty, free_space
//
// Each request beat ends in S_RESULT: push start via S_HDR_WRITE, pop start via S_HDR_READ,
// S_POP_CALC and S_POP_SETUP, pop byte via S_POP_DATA, push byte, clear and refused items
// directly. Every store byte goes through a single-port-per-direction byte-wide RAM, so the
// four header bytes move singly; a header read waits on read data and length arithmetic.
// Reset is synchronous and active high; it empties the queue at once, as the store
// contents need no clearing.
// A response beat waits in an output register; the next request beat is taken while
// it waits, and the sequencer holds its own result only when that register is still full.
module length_prefixed_record_fifo_core (
   input logic      clock,
   input logic      reset,
   lprf_req_if.sink   req_ch,
   lprf_rsp_if.source rsp_ch
);

   lprf_pkg::ram_req_type ram_req;
   lprf_pkg::byte_type    ram_rd_data;
   lprf_pkg::result_type  seq_res;
   logic                  seq_res_valid;

   logic                  rsp_valid_ff, rsp_valid_in;
   lprf_pkg::result_type  rsp_data_ff, rsp_data_in;
   logic                  slot_free;
   logic                  slot_load;

   // The sequencer owns all queue state and drives the byte store.
   lprf_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .slot_free   (slot_free),
      .ram_rd_data (ram_rd_data),
      .ram_req     (ram_req),
      .res_valid   (seq_res_valid),
      .res         (seq_res)
   );

   // Circular byte store. Only one access happens per cycle, and a pop never reaches
   // a byte in the same cycle that it is written, so no bypass is needed.
   lprf_ram #(
      .WIDTH ($bits(lprf_pkg::byte_type)),
      .DEPTH (lprf_pkg::CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rd_data)
   );

   // The response register may be refilled in the cycle its beat is taken.
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign slot_load = seq_res_valid && slot_free;

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (slot_load) begin
         rsp_data_in  = seq_res;
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_data_ff.status;
   assign rsp_ch.read_byte     = rsp_data_ff.read_byte;
   assign rsp_ch.stored_length = rsp_data_ff.stored_length;
   assign rsp_ch.last_byte     = rsp_data_ff.last_byte;
   assign rsp_ch.queue_empty   = rsp_data_ff.queue_empty;
   assign rsp_ch.free_space    = rsp_data_ff.free_space;

endmodule

[bench/length_prefixed_record_fifo_core_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the length-prefixed record FIFO core, with its own record model.
module length_prefixed_record_fifo_core_test;
   import lprf_pkg::*;

   localparam int CLOCK_PERIOD  = 20;
   localparam int RESET_CYCLES  = 5;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int REPORT_LIMIT  = 100;
   localparam int SETTLE_CYCLES = 16;
   localparam int PHASE_BEATS   = 342;
   localparam int ACTION_CODES  = 1 << ACTION_W;
   localparam int COUNT_MAX     = (1 << BYTE_COUNT_W) - 1;
   localparam int BYTE_MAX      = (1 << DATA_W) - 1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lprf_req_if req_ch ();
   lprf_rsp_if rsp_ch ();

   length_prefixed_record_fifo_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Private copy of the record store and its bookkeeping.
   byte_type store_copy [CAPACITY];
   int read_at       = 0;
   int write_at      = 0;
   int free_left     = CAPACITY;
   int push_left     = 0;
   int pop_left      = 0;
   int record_end_at = 0;
   int record_bytes  = 0;

   result_type predicted_responses [$];

   int mismatches        = 0;
   int cycle_count       = 0;
   int sender_idle_pct   = 6;
   int receiver_idle_pct = 72;

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Skips the unread tail of the record being popped and gives its space back.
   function automatic void release_record();
      read_at = record_end_at;
      free_left += record_bytes + HDR_BYTES;
      if (free_left > CAPACITY) begin
         free_left = CAPACITY;
      end
      pop_left = 0;
   endfunction

   // Applies one request beat to the record model and returns the response it earns.
   function automatic result_type fifo_response(input logic [ACTION_W-1:0] act,
                                                input int count, input int data);
      result_type rsp;
      int         hdr;
      rsp = '0;
      rsp.status = STS_OK;
      case (act)
         ACT_PUSH_START: begin
            if (push_left != 0 || pop_left != 0) begin
               rsp.status = STS_SEQ;
            end else if (free_left < count + HDR_BYTES) begin
               rsp.status = STS_NO_ROOM;
            end else begin
               for (int i = 0; i < HDR_BYTES; i++) begin
                  store_copy[write_at] = byte_type'(count >> (8 * i));
                  write_at = (write_at + 1) % CAPACITY;
               end
               free_left -= count + HDR_BYTES;
               push_left = count;
            end
         end
         ACT_PUSH_BYTE: begin
            if (push_left == 0) begin
               rsp.status = STS_SEQ;
            end else begin
               store_copy[write_at] = byte_type'(data);
               write_at = (write_at + 1) % CAPACITY;
               push_left--;
            end
         end
         ACT_POP_START: begin
            if (push_left != 0 || pop_left != 0) begin
               rsp.status = STS_SEQ;
            end else if (free_left == CAPACITY) begin
               rsp.status = STS_EMPTY;
            end else begin
               hdr = 0;
               for (int i = 0; i < HDR_BYTES; i++) begin
                  hdr |= int'(store_copy[read_at]) << (8 * i);
                  read_at = (read_at + 1) % CAPACITY;
               end
               if (hdr > CAPACITY) begin
                  hdr = CAPACITY;
               end
               record_bytes = hdr;
               record_end_at = (read_at + hdr) % CAPACITY;
               rsp.stored_length = stored_len_type'(hdr);
               pop_left = (hdr < count) ? hdr : count;
               // A copy limit of zero finishes the record straight away.
               if (pop_left == 0) begin
                  release_record();
               end
            end
         end
         ACT_POP_BYTE: begin
            if (pop_left == 0) begin
               rsp.status = STS_SEQ;
            end else begin
               rsp.read_byte = store_copy[read_at];
               read_at = (read_at + 1) % CAPACITY;
               pop_left--;
               if (pop_left == 0) begin
                  rsp.last_byte = 1'b1;
                  release_record();
               end
            end
         end
         ACT_CLEAR: begin
            free_left = CAPACITY;
            read_at = write_at;
            push_left = 0;
            pop_left = 0;
         end
         default: begin
            rsp.status = STS_SEQ;
         end
      endcase
      rsp.queue_empty = (free_left == CAPACITY);
      rsp.free_space = free_space_type'(free_left);
      return rsp;
   endfunction

   // Offers one request beat, idling first at random, and records the response it should get.
   task automatic send_beat(input logic [ACTION_W-1:0] act, input int count, input int data);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.action     <= act;
      req_ch.byte_count <= byte_count_type'(count);
      req_ch.data_byte  <= byte_type'(data);
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      predicted_responses.push_back(fifo_response(act, count & COUNT_MAX, data & BYTE_MAX));
   endtask

   // Stops offering beats until every predicted response has been collected.
   task automatic hold_until_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (predicted_responses.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic check_field(input string field, input int expected_value,
                              input int actual_value);
      if (expected_value != actual_value) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $error("%s: expected %0d, actual %0d", field, expected_value, actual_value);
         end
      end
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   always @(posedge clock) begin : response_check
      result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (predicted_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $error("response beat with no expectation waiting");
            end
         end else begin
            want = predicted_responses.pop_front();
            check_field("status", int'(want.status), int'(rsp_ch.status));
            check_field("read_byte", int'(want.read_byte), int'(rsp_ch.read_byte));
            check_field("stored_length", int'(want.stored_length),
                        int'(rsp_ch.stored_length));
            check_field("last_byte", int'(want.last_byte), int'(rsp_ch.last_byte));
            check_field("queue_empty", int'(want.queue_empty), int'(rsp_ch.queue_empty));
            check_field("free_space", int'(want.free_space), int'(rsp_ch.free_space));
         end
      end
   end

   // Beats that must be refused: empty pops, stray byte beats, unknown actions, no room.
   task automatic test_refused_beats();
      send_beat(ACT_POP_START, 1, 0);
      send_beat(ACT_POP_BYTE, 0, 0);
      send_beat(ACT_PUSH_BYTE, 0, BYTE_MAX);
      for (int code = int'(ACT_CLEAR) + 1; code < ACTION_CODES; code++) begin
         send_beat(ACTION_W'(code), COUNT_MAX, BYTE_MAX);
      end
      send_beat(ACT_PUSH_START, COUNT_MAX, 0);
   endtask

   // Short records, starts while busy, a truncated pop and zero-length cases.
   task automatic test_record_handshakes();
      send_beat(ACT_PUSH_START, 0, 0);
      send_beat(ACT_POP_START, 5, 0);
      send_beat(ACT_PUSH_START, 3, 0);
      send_beat(ACT_PUSH_BYTE, 0, 8'h00);
      send_beat(ACT_PUSH_START, 1, 0);
      send_beat(ACT_PUSH_BYTE, 0, 8'hFF);
      send_beat(ACT_POP_START, 3, 0);
      send_beat(ACT_PUSH_BYTE, COUNT_MAX, 8'hA5);
      // Only two of the three bytes are wanted, so the last one is skipped.
      send_beat(ACT_POP_START, 2, 0);
      send_beat(ACT_PUSH_START, 4, 0);
      send_beat(ACT_POP_BYTE, 0, 0);
      send_beat(ACT_POP_BYTE, 0, 0);
      send_beat(ACT_POP_BYTE, 0, 0);
      send_beat(ACT_PUSH_START, 1, 0);
      send_beat(ACT_PUSH_BYTE, 0, 8'h5A);
      send_beat(ACT_POP_START, 0, 0);
   endtask

   // Reserving the largest record leaves no space at all; clear must drop the pending push.
   task automatic test_full_store_clear();
      send_beat(ACT_PUSH_START, CAPACITY - HDR_BYTES, 0);
      send_beat(ACT_CLEAR, 0, 0);
   endtask

   // Mostly whole records with random contents, mixed with stray and random beats.
   task automatic test_random_records(input int beats);
      int roll;
      int length;
      for (int n = 0; n < beats; n++) begin
         roll = $urandom_range(99);
         if (roll < 6) begin
            send_beat(ACTION_W'($urandom_range(ACTION_CODES - 1)), $urandom_range(COUNT_MAX),
                      $urandom_range(BYTE_MAX));
         end else if (push_left != 0) begin
            send_beat(ACT_PUSH_BYTE, $urandom_range(COUNT_MAX), $urandom_range(BYTE_MAX));
         end else if (pop_left != 0) begin
            send_beat(ACT_POP_BYTE, $urandom_range(COUNT_MAX), $urandom_range(BYTE_MAX));
         end else begin
            roll = $urandom_range(99);
            if (roll < 55) begin
               // Most records are short; a few are long and a few cannot fit.
               roll = $urandom_range(99);
               if (roll < 8) begin
                  length = 0;
               end else if (roll < 75) begin
                  length = $urandom_range(12, 1);
               end else if (roll < 94) begin
                  length = $urandom_range(64, 13);
               end else if (roll < 98) begin
                  length = $urandom_range(300, 65);
               end else begin
                  length = $urandom_range(COUNT_MAX, CAPACITY - HDR_BYTES);
               end
               send_beat(ACT_PUSH_START, length, $urandom_range(BYTE_MAX));
            end else if (roll < 95) begin
               roll = $urandom_range(99);
               if (roll < 15) begin
                  length = 0;
               end else if (roll < 75) begin
                  length = $urandom_range(16, 1);
               end else begin
                  length = $urandom_range(COUNT_MAX);
               end
               send_beat(ACT_POP_START, length, $urandom_range(BYTE_MAX));
            end else begin
               send_beat(ACT_CLEAR, $urandom_range(COUNT_MAX), $urandom_range(BYTE_MAX));
            end
         end
      end
   endtask

   initial begin
      req_ch.valid      = 1'b0;
      req_ch.action     = '0;
      req_ch.byte_count = '0;
      req_ch.data_byte  = '0;
      rsp_ch.ready      = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Slow receiver first.
      sender_idle_pct = 6;
      receiver_idle_pct = 72;
      test_refused_beats();
      test_record_handshakes();
      test_full_store_clear();
      test_random_records(PHASE_BEATS);
      hold_until_drained();

      // Then a slow sender.
      sender_idle_pct = 72;
      receiver_idle_pct = 6;
      test_random_records(PHASE_BEATS);
      hold_until_drained();

      // Finally both sides at full rate.
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      test_random_records(PHASE_BEATS);
      hold_until_drained();

      // Any late beat would show up here as one with no expectation waiting.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && predicted_responses.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
